/* hw/rtl/vsv_pkg.sv */
// Shared constants and register codes for the Vreman eddy viscosity block.
package vsv_pkg;

  localparam int DATA_WIDTH_DEF = 32;  // default gradient precision
  localparam int GRAD_PORT_W    = 32;  // gradient ports, Q16.16
  localparam int VOL_W          = 32;  // cell volume, Q0.32
  localparam int RHO_W          = 32;  // density, Q16.16
  localparam int OUT_W          = 32;  // viscosity, Q16.16
  localparam int COEF_W         = 16;  // model coefficients, Q0.16
  localparam int WORD_W         = 32;  // chunk width for split products
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [COEF_W-1:0] VREMAN_RESET = 16'd4588;  // 0.07
  localparam logic [COEF_W-1:0] CLIP_RESET   = 16'd3277;  // 0.05

  typedef enum logic {
    REG_VREMAN = 1'b0,
    REG_CLIP   = 1'b1
  } cfg_reg_t;

endpackage

/* hw/rtl/vsv_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module vsv_div #(
  parameter int NW = 132,
  parameter int QW = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NW-1:0]    num,
  input  logic [NW-QW-1:0] den,
  output logic [QW-1:0]    quo
);

  localparam int RW = NW - QW;

  // upper part of the numerator is always below the divisor
  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] low_q [QW-1];
  logic [RW-1:0] den_q [QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [QW-1:0] low_in;
    logic [RW-1:0] den_in;
    logic [RW:0]   r2;
    logic [RW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num[NW-1:QW];
      assign quo_in = '0;
      assign low_in = num[QW-1:0];
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign r2   = {rem_in, low_in[QW-1]};
    assign ge   = r2 >= {1'b0, den_in};
    assign diff = r2 - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? diff[RW-1:0] : r2[RW-1:0];
        quo_q[s] <= {quo_in[QW-2:0], ge};
      end
    end

    if (s < QW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          low_q[s] <= {low_in[QW-2:0], 1'b0};
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

/* hw/rtl/vsv_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module vsv_isqrt #(
  parameter int IW = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IW-1:0]     x,
  output logic [IW/2-1:0]   root
);

  localparam int OW = IW / 2;

  logic [OW:0]   rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [IW-1:0] x_q    [OW-1];

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [OW:0]   rem_in;
    logic [OW-1:0] root_in;
    logic [IW-1:0] x_in;
    logic [OW+2:0] r4;
    logic [OW+2:0] trial;
    logic [OW+2:0] diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign x_in    = x_q[s-1];
    end

    assign r4    = {rem_in, x_in[IW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = r4 >= trial;
    assign diff  = r4 - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? diff[OW:0] : r4[OW:0];
        root_q[s] <= {root_in[OW-2:0], ge};
      end
    end

    if (s < OW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          x_q[s] <= {x_in[IW-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[OW-1];

endmodule

/* hw/rtl/vreman_sgs_viscosity.sv */
// Top level of the Vreman subgrid-scale eddy viscosity pipeline.
//
// One mesh cell per request: nine Q16.16 velocity gradients, the cell volume
// (Q0.32 of the reference volume) and the density (Q16.16) go in; the eddy
// viscosity rho*dx2*min(c*sqrt(B/|a|^2), k*sqrt(2|a|^2)) comes out in
// saturating Q16.16 with a flag that is set when the clip term was the
// smaller one. dx2 = volume^(2/3). A new request is taken every cycle
// while the pipeline is not held (see below); the latency is set by the
// bit-per-stage divider for B/|a|^2 (2*GW stages) followed by the square
// root of the quotient (GW stages). |a|^2 and the squared minors take five
// stages ahead of that; the coefficient products, the minimum and the split
// density and volume products take six behind it. Every stage moves on one
// enable: while the output register holds a result that has not been taken,
// the whole pipeline holds, and in_ready is low. A zero gradient gives zero.
// Coefficients sit on an APB port at 0x0 (c) and 0x4 (k), Q0.16, and may be
// rewritten only while no request is in flight. No clearing pass after reset.
module vreman_sgs_viscosity
  import vsv_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [GRAD_PORT_W-1:0] grad_11,
  input  logic signed [GRAD_PORT_W-1:0] grad_12,
  input  logic signed [GRAD_PORT_W-1:0] grad_13,
  input  logic signed [GRAD_PORT_W-1:0] grad_21,
  input  logic signed [GRAD_PORT_W-1:0] grad_22,
  input  logic signed [GRAD_PORT_W-1:0] grad_23,
  input  logic signed [GRAD_PORT_W-1:0] grad_31,
  input  logic signed [GRAD_PORT_W-1:0] grad_32,
  input  logic signed [GRAD_PORT_W-1:0] grad_33,
  input  logic [VOL_W-1:0]              cell_volume,
  input  logic [RHO_W-1:0]              density,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OUT_W-1:0]              eddy_viscosity,
  output logic                          was_clipped,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  // gradient precision actually used
  localparam int GW  = (DATA_WIDTH < GRAD_PORT_W) ? DATA_WIDTH : GRAD_PORT_W;
  localparam int PW  = 2 * GW;            // products and minors
  localparam int LW  = 2 * GW + 4;        // |a|^2
  localparam int SW  = 4 * GW;            // squared minor
  localparam int BW  = 4 * GW + 4;        // B
  localparam int QW  = 2 * GW;            // B / |a|^2
  localparam int PIW = 2 * GW + 6;        // 2|a|^2, padded to even width
  localparam int PRW = PIW / 2;           // sqrt(2|a|^2)
  localparam int VW2 = 2 * VOL_W;
  localparam int VW3 = 3 * VOL_W;
  localparam int CQW = COEF_W + GW;       // c*q
  localparam int MW  = COEF_W + PRW;      // k*p and the minimum
  localparam int TW  = MW + WORD_W;       // m*rho
  localparam int FW  = MW + 2 * WORD_W + 1;
  localparam int UL  = 3 * GW;            // divider plus square root
  localparam int NV  = 11 + UL;           // total stages
  localparam int DP  = UL - PRW;          // alignment of sqrt(2|a|^2)
  localparam int DV  = UL - VOL_W;        // alignment of dx2

  // ---------------------------------------------------------------- config
  logic [COEF_W-1:0] vreman_coefficient;
  logic [COEF_W-1:0] clip_coefficient;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vreman_coefficient <= VREMAN_RESET;
      clip_coefficient   <= CLIP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(paddr[2]))
        REG_VREMAN: vreman_coefficient <= pwdata[COEF_W-1:0];
        REG_CLIP:   clip_coefficient   <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[2]))
      REG_VREMAN: prdata = PDATA_W'(vreman_coefficient);
      REG_CLIP:   prdata = PDATA_W'(clip_coefficient);
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------------- flow control
  logic          en;
  logic [NV-1:0] vld;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end

  // ------------------------------------------- stage 1: gradient products
  logic signed [GW-1:0] ga [9];
  logic signed [PW-1:0] gx [9];

  assign ga[0] = grad_11[GW-1:0];
  assign ga[1] = grad_12[GW-1:0];
  assign ga[2] = grad_13[GW-1:0];
  assign ga[3] = grad_21[GW-1:0];
  assign ga[4] = grad_22[GW-1:0];
  assign ga[5] = grad_23[GW-1:0];
  assign ga[6] = grad_31[GW-1:0];
  assign ga[7] = grad_32[GW-1:0];
  assign ga[8] = grad_33[GW-1:0];

  for (genvar k = 0; k < 9; k++) begin : g_ext
    assign gx[k] = {{GW{ga[k][GW-1]}}, ga[k]};
  end

  logic [PW-1:0]        s1_sq [9];
  logic signed [PW-1:0] s1_p1 [9];
  logic signed [PW-1:0] s1_p2 [9];
  logic [VW2-1:0]       s1_vol2;
  logic [RHO_W-1:0]     s1_rho;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        s1_sq[k] <= gx[k] * gx[k];
      end
      s1_vol2 <= VW2'(cell_volume) * VW2'(cell_volume);
      s1_rho  <= density;
    end
  end

  // 2x2 minors: row pair ri, column pair ci, each one of (1,2) (1,3) (2,3)
  for (genvar ri = 0; ri < 3; ri++) begin : g_mrow
    for (genvar ci = 0; ci < 3; ci++) begin : g_mcol
      localparam int R1 = (ri == 2) ? 1 : 0;
      localparam int R2 = (ri == 0) ? 1 : 2;
      localparam int C1 = (ci == 2) ? 1 : 0;
      localparam int C2 = (ci == 0) ? 1 : 2;
      always_ff @(posedge clk) begin
        if (en) begin
          s1_p1[3*ri+ci] <= gx[3*R1+C1] * gx[3*R2+C2];
          s1_p2[3*ri+ci] <= gx[3*R1+C2] * gx[3*R2+C1];
        end
      end
    end
  end

  // ------------------------------------- stage 2: |a|^2, minor magnitudes
  logic [LW-1:0]    lsum;
  logic [PW-1:0]    mag [9];
  logic [LW-1:0]    s2_l;
  logic [PW-1:0]    s2_mag [9];
  logic [VW2-1:0]   s2_vol2;
  logic [RHO_W-1:0] s2_rho;

  always_comb begin
    lsum = '0;
    for (int k = 0; k < 9; k++) begin
      lsum = lsum + LW'(s1_sq[k]);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_mag
    logic [PW:0] dif;
    logic [PW:0] neg;
    assign dif    = {s1_p1[k][PW-1], s1_p1[k]} - {s1_p2[k][PW-1], s1_p2[k]};
    assign neg    = '0 - dif;
    assign mag[k] = dif[PW] ? neg[PW-1:0] : dif[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_l    <= lsum;
      s2_mag  <= mag;
      s2_vol2 <= s1_vol2;
      s2_rho  <= s1_rho;
    end
  end

  // ------------------------------------ stage 3: partial squares of minors
  logic [PW-1:0]    s3_hh [9];
  logic [PW-1:0]    s3_hl [9];
  logic [PW-1:0]    s3_ll [9];
  logic [LW-1:0]    s3_l;
  logic [VW2-1:0]   s3_vol2;
  logic [RHO_W-1:0] s3_rho;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        s3_hh[k] <= PW'(s2_mag[k][PW-1:GW]) * PW'(s2_mag[k][PW-1:GW]);
        s3_hl[k] <= PW'(s2_mag[k][PW-1:GW]) * PW'(s2_mag[k][GW-1:0]);
        s3_ll[k] <= PW'(s2_mag[k][GW-1:0]) * PW'(s2_mag[k][GW-1:0]);
      end
      s3_l    <= s2_l;
      s3_vol2 <= s2_vol2;
      s3_rho  <= s2_rho;
    end
  end

  // --------------------------------------------- stage 4: squared minors
  logic [SW-1:0]    s4_sq [9];
  logic [LW-1:0]    s4_l;
  logic [VW2-1:0]   s4_vol2;
  logic [RHO_W-1:0] s4_rho;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        s4_sq[k] <= {s3_hh[k], s3_ll[k]} + (SW'(s3_hl[k]) << (GW + 1));
      end
      s4_l    <= s3_l;
      s4_vol2 <= s3_vol2;
      s4_rho  <= s3_rho;
    end
  end

  // ------------------------------------------------------- stage 5: B
  logic [BW-1:0]    bsum;
  logic [BW-1:0]    s5_b;
  logic [LW-1:0]    s5_l;
  logic [VW2-1:0]   s5_vol2;
  logic [RHO_W-1:0] s5_rho;

  always_comb begin
    bsum = '0;
    for (int k = 0; k < 9; k++) begin
      bsum = bsum + BW'(s4_sq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_b    <= bsum;
      s5_l    <= s4_l;
      s5_vol2 <= s4_vol2;
      s5_rho  <= s4_rho;
    end
  end

  // ------------------------------------- long units: divide, roots, cbrt
  logic [QW-1:0]  ratio;
  logic [GW-1:0]  q_root;
  logic [PRW-1:0] p_root;

  vsv_div #(
    .NW (BW),
    .QW (QW)
  ) u_div (
    .clk (clk),
    .en  (en),
    .num (s5_b),
    .den (s5_l),
    .quo (ratio)
  );

  vsv_isqrt #(
    .IW (QW)
  ) u_sqrt_q (
    .clk  (clk),
    .en   (en),
    .x    (ratio),
    .root (q_root)
  );

  vsv_isqrt #(
    .IW (PIW)
  ) u_sqrt_p (
    .clk  (clk),
    .en   (en),
    .x    ({1'b0, s5_l, 1'b0}),
    .root (p_root)
  );

  // filter width squared: floor(cbrt(vol^2 * 2^32)), one bit per stage,
  // keeping y^2 and y^3 so each stage is adds and a compare
  logic [VOL_W-1:0] cy_q  [VOL_W];
  logic [VW2-1:0]   cy2_q [VOL_W-1];
  logic [VW3-1:0]   cy3_q [VOL_W-1];
  logic [VW3-1:0]   ctg_q [VOL_W-1];

  for (genvar s = 0; s < VOL_W; s++) begin : g_cbrt
    localparam int B = VOL_W - 1 - s;
    logic [VOL_W-1:0] y_in;
    logic [VW2-1:0]   y2_in;
    logic [VW3-1:0]   y3_in;
    logic [VW3-1:0]   tg_in;
    logic [VW3-1:0]   t3;
    logic [VW2-1:0]   t2;
    logic             ge;

    if (s == 0) begin : g_first
      assign y_in  = '0;
      assign y2_in = '0;
      assign y3_in = '0;
      assign tg_in = {s5_vol2, VOL_W'(0)};
    end else begin : g_next
      assign y_in  = cy_q[s-1];
      assign y2_in = cy2_q[s-1];
      assign y3_in = cy3_q[s-1];
      assign tg_in = ctg_q[s-1];
    end

    assign t3 = y3_in
              + ((VW3'(y2_in) + (VW3'(y2_in) << 1)) << B)
              + ((VW3'(y_in) + (VW3'(y_in) << 1)) << (2 * B))
              + (VW3'(1) << (3 * B));
    assign t2 = y2_in + (VW2'(y_in) << (B + 1)) + (VW2'(1) << (2 * B));
    assign ge = tg_in >= t3;

    always_ff @(posedge clk) begin
      if (en) begin
        cy_q[s] <= ge ? (y_in | (VOL_W'(1) << B)) : y_in;
      end
    end

    if (s < VOL_W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          cy2_q[s] <= ge ? t2 : y2_in;
          cy3_q[s] <= ge ? t3 : y3_in;
          ctg_q[s] <= tg_in;
        end
      end
    end
  end

  // alignment lines up to the end of the quotient root
  logic [PRW-1:0]   p_dl  [DP];
  logic [VOL_W-1:0] dx_dl [DV];
  logic [RHO_W:0]   rz_dl [UL];   // {zero gradient, density}

  always_ff @(posedge clk) begin
    if (en) begin
      p_dl[0]  <= p_root;
      dx_dl[0] <= cy_q[VOL_W-1];
      rz_dl[0] <= {(s5_l == '0), s5_rho};
      for (int i = 1; i < DP; i++) begin
        p_dl[i] <= p_dl[i-1];
      end
      for (int i = 1; i < DV; i++) begin
        dx_dl[i] <= dx_dl[i-1];
      end
      for (int i = 1; i < UL; i++) begin
        rz_dl[i] <= rz_dl[i-1];
      end
    end
  end

  // --------------------------------------- E1: coefficient products
  logic [GW-1:0]    q_eff;
  logic [CQW-1:0]   e1_vre;
  logic [MW-1:0]    e1_clp;
  logic [RHO_W-1:0] e1_rho;
  logic [VOL_W-1:0] e1_dx;

  assign q_eff = rz_dl[UL-1][RHO_W] ? '0 : q_root;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_vre <= CQW'(vreman_coefficient) * CQW'(q_eff);
      e1_clp <= MW'(clip_coefficient) * MW'(p_dl[DP-1]);
      e1_rho <= rz_dl[UL-1][RHO_W-1:0];
      e1_dx  <= dx_dl[DV-1];
    end
  end

  // --------------------------------------------------- E2: minimum
  logic             e2_clip;
  logic [MW-1:0]    e2_m;
  logic [RHO_W-1:0] e2_rho;
  logic [VOL_W-1:0] e2_dx;
  logic             clip_lt;

  assign clip_lt = e1_clp < MW'(e1_vre);

  always_ff @(posedge clk) begin
    if (en) begin
      e2_clip <= clip_lt;
      e2_m    <= clip_lt ? e1_clp : MW'(e1_vre);
      e2_rho  <= e1_rho;
      e2_dx   <= e1_dx;
    end
  end

  // ------------------------------------------ E3: m * rho, two halves
  logic [2*WORD_W-1:0] e3_lo;
  logic [MW-1:0]       e3_hi;
  logic                e3_clip;
  logic [VOL_W-1:0]    e3_dx;

  always_ff @(posedge clk) begin
    if (en) begin
      e3_lo   <= (2*WORD_W)'(e2_m[WORD_W-1:0]) * (2*WORD_W)'(e2_rho);
      e3_hi   <= MW'(e2_m[MW-1:WORD_W]) * MW'(e2_rho);
      e3_clip <= e2_clip;
      e3_dx   <= e2_dx;
    end
  end

  // ------------------------------------------------ E4: join halves
  logic [TW-1:0]    e4_t;
  logic             e4_clip;
  logic [VOL_W-1:0] e4_dx;

  always_ff @(posedge clk) begin
    if (en) begin
      e4_t    <= {e3_hi, WORD_W'(0)} + TW'(e3_lo);
      e4_clip <= e3_clip;
      e4_dx   <= e3_dx;
    end
  end

  // ---------------------------------------- E5: times dx2, in chunks
  logic [2*WORD_W-1:0] e5_d0;
  logic [2*WORD_W-1:0] e5_d1;
  logic [MW-1:0]       e5_d2;
  logic                e5_clip;

  always_ff @(posedge clk) begin
    if (en) begin
      e5_d0   <= (2*WORD_W)'(e4_t[WORD_W-1:0]) * (2*WORD_W)'(e4_dx);
      e5_d1   <= (2*WORD_W)'(e4_t[2*WORD_W-1:WORD_W]) * (2*WORD_W)'(e4_dx);
      e5_d2   <= MW'(e4_t[TW-1:2*WORD_W]) * MW'(e4_dx);
      e5_clip <= e4_clip;
    end
  end

  // ------------------------------------- E6: sum, scale, saturate, output
  logic [FW-1:0]   full;
  logic [MW:0]     scaled;

  assign full   = FW'(e5_d0) + (FW'(e5_d1) << WORD_W) + (FW'(e5_d2) << (2 * WORD_W));
  assign scaled = full[FW-1:2*WORD_W];

  always_ff @(posedge clk) begin
    if (en) begin
      eddy_viscosity <= (scaled[MW:OUT_W] != '0) ? '1 : scaled[OUT_W-1:0];
      was_clipped    <= e5_clip;
    end
  end

endmodule
